// ===== rtl/core/lightbar_menu_navigator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lightbar menu navigator assertion macros
// shared concurrent check forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LIGHTBAR_MENU_NAVIGATOR_UNIT_DEFINES_SVH
`define LIGHTBAR_MENU_NAVIGATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define LMN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LMN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_pkg
// shared types, codes and helpers of the lightbar menu navigator
// ----------------------------------------------------------------------------
package lmn_pkg;

   localparam int TABLE_LIMIT = 8;
   localparam int IDX_W       = 3;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_BEGIN,
      OP_KEY,
      OP_LOST
   } op_type;

   typedef enum logic [2:0] {
      ST_WRITTEN,
      ST_STARTED,
      ST_EMPTY,
      ST_MOVED,
      ST_CONSUMED,
      ST_CHOSEN,
      ST_ABORTED,
      ST_INACTIVE
   } status_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_OPEN,
      ESC_CSI
   } esc_type;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_RIGHT,
      DIR_LEFT
   } dir_type;

   typedef enum logic [1:0] {
      JOB_CONFIRM,
      JOB_ARROW,
      JOB_HOTKEY
   } job_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CUR,
      SEQ_SCAN,
      SEQ_DONE
   } seq_state_type;

   // register indexes of the csr port
   localparam logic CSR_OPTION_COUNT = 1'b0;
   localparam logic CSR_START_INDEX  = 1'b1;

   localparam logic [7:0] KEY_ESC     = 8'd27;
   localparam logic [7:0] KEY_CSI     = 8'h5B;
   localparam logic [7:0] KEY_SS3     = 8'h4F;
   localparam logic [7:0] KEY_CR      = 8'h0D;
   localparam logic [7:0] KEY_LF      = 8'h0A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;
   localparam logic [7:0] KEY_A       = 8'h41;
   localparam logic [7:0] KEY_B       = 8'h42;
   localparam logic [7:0] KEY_C       = 8'h43;
   localparam logic [7:0] KEY_D       = 8'h44;
   localparam logic [7:0] KEY_Z       = 8'h5A;

   typedef struct packed {
      op_type     operation;
      logic [2:0] entry_index;
      logic [7:0] entry_row;
      logic [7:0] entry_col;
      logic [7:0] entry_hotkey;
      logic [7:0] key_byte;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [2:0] old_index;
      logic [2:0] new_index;
      logic [7:0] chosen_key;
      logic       menu_active;
   } rsp_type;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] hotkey;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= KEY_A && c <= KEY_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

// ===== rtl/core/lmn_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_req_if
// request channel: entry writes, begin, keystrokes and input lost
// ----------------------------------------------------------------------------
interface lmn_req_if;
   logic                valid;
   logic                ready;
   lmn_pkg::op_type     operation;
   logic [2:0]          entry_index;
   logic [7:0]          entry_row;
   logic [7:0]          entry_col;
   logic [7:0]          entry_hotkey;
   logic [7:0]          key_byte;

   modport source (
      output valid, operation, entry_index, entry_row, entry_col, entry_hotkey, key_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, entry_row, entry_col, entry_hotkey, key_byte,
      output ready
   );
endinterface

// ===== rtl/core/lmn_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_rsp_if
// response channel: one result per request transaction
// ----------------------------------------------------------------------------
interface lmn_rsp_if;
   logic                   valid;
   logic                   ready;
   lmn_pkg::status_type    status;
   logic [2:0]             old_index;
   logic [2:0]             new_index;
   logic [7:0]             chosen_key;
   logic                   menu_active;

   modport source (
      output valid, status, old_index, new_index, chosen_key, menu_active,
      input  ready
   );
   modport sink (
      input  valid, status, old_index, new_index, chosen_key, menu_active,
      output ready
   );
endinterface

// ===== rtl/core/lmn_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_csr_if
// register write channel: index and write data
// ----------------------------------------------------------------------------
interface lmn_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [3:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== rtl/core/lmn_option_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_option_mem
// option table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lmn_option_mem #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  lmn_pkg::mem_req_type mem_req,
   output lmn_pkg::entry_type   rd_data
);
   import lmn_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lmn_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_seq
// menu sequencer: decodes transactions, scans the option table, keeps state
// ----------------------------------------------------------------------------
module lmn_seq #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lmn_pkg::req_type     req,
   input  logic [3:0]           option_count,
   input  logic [2:0]           start_index,
   output lmn_pkg::mem_req_type mem_req,
   input  lmn_pkg::entry_type   rd_data,
   output logic                 res_valid,
   input  logic                 res_ready,
   output lmn_pkg::rsp_type     res
);
   import lmn_pkg::*;

   localparam int         AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int         CW      = $clog2(DEPTH + 1);
   localparam logic [3:0] DEPTH_N = 4'(DEPTH);

   seq_state_type state_ff, state_in;
   job_type       job_ff, job_in;
   dir_type       dir_ff, dir_in;
   logic [7:0]    key_ff, key_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [7:0]    cur_row_ff, cur_row_in;
   logic [7:0]    cur_col_ff, cur_col_in;
   logic          found_ff, found_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [7:0]    best_p_ff, best_p_in;
   logic [7:0]    best_s_ff, best_s_in;
   logic [7:0]    best_key_ff, best_key_in;
   logic [AW-1:0] sel_ff, sel_in;
   esc_type       esc_ff, esc_in;
   logic          active_ff, active_in;
   rsp_type       res_ff, res_in;

   logic [3:0]    n_full;
   logic [CW-1:0] n;

   // live option count limited to the table depth
   assign n_full = (option_count > DEPTH_N) ? DEPTH_N : option_count;
   assign n      = n_full[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         sel_ff     <= '0;
         esc_ff     <= ESC_NONE;
         active_ff  <= 1'b0;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sel_ff     <= sel_in;
         esc_ff     <= esc_in;
         active_ff  <= active_in;
         chk_vld_ff <= chk_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      dir_ff      <= dir_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      best_idx_ff <= best_idx_in;
      best_p_ff   <= best_p_in;
      best_s_ff   <= best_s_in;
      best_key_ff <= best_key_in;
      res_ff      <= res_in;
   end

   always_comb begin
      logic       finish;
      status_type fin_status;
      logic [7:0] fin_key;
      logic [7:0] r;
      logic [7:0] c;
      logic [7:0] p;
      logic [7:0] s;
      logic       ok;
      logic       issue;

      state_in    = state_ff;
      job_in      = job_ff;
      dir_in      = dir_ff;
      key_in      = key_ff;
      cnt_in      = cnt_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_p_in   = best_p_ff;
      best_s_in   = best_s_ff;
      best_key_in = best_key_ff;
      sel_in      = sel_ff;
      esc_in      = esc_ff;
      active_in   = active_ff;
      res_in      = res_ff;

      mem_req         = '0;
      mem_req.rd_addr = IDX_W'(sel_ff);
      req_ready       = (state_ff == SEQ_IDLE);
      res_valid       = (state_ff == SEQ_DONE);

      finish     = 1'b0;
      fin_status = ST_CONSUMED;
      fin_key    = '0;
      r          = rd_data.row;
      c          = rd_data.col;
      p          = '0;
      s          = '0;
      ok         = 1'b0;
      issue      = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               case (req.operation)
                  OP_WRITE: begin
                     mem_req.wr_en   = ({1'b0, req.entry_index} < DEPTH_N);
                     mem_req.wr_addr = req.entry_index;
                     mem_req.wr_data = '{row: req.entry_row, col: req.entry_col,
                                         hotkey: req.entry_hotkey};
                     finish     = 1'b1;
                     fin_status = ST_WRITTEN;
                  end
                  OP_BEGIN: begin
                     esc_in = ESC_NONE;
                     finish = 1'b1;
                     if (n_full == 4'd0) begin
                        active_in  = 1'b0;
                        fin_status = ST_EMPTY;
                     end else begin
                        sel_in     = ({1'b0, start_index} < n_full) ?
                                     start_index[AW-1:0] : '0;
                        active_in  = 1'b1;
                        fin_status = ST_STARTED;
                     end
                  end
                  default: begin
                     if (!active_ff) begin
                        finish     = 1'b1;
                        fin_status = ST_INACTIVE;
                     end else if (req.operation == OP_LOST) begin
                        active_in  = 1'b0;
                        esc_in     = ESC_NONE;
                        finish     = 1'b1;
                        fin_status = ST_ABORTED;
                     end else begin
                        case (esc_ff)
                           ESC_OPEN: begin
                              esc_in = (req.key_byte inside {KEY_CSI, KEY_SS3}) ?
                                       ESC_CSI : ESC_NONE;
                              finish = 1'b1;
                           end
                           ESC_CSI: begin
                              esc_in = ESC_NONE;
                              if (req.key_byte inside {[KEY_A:KEY_D]}) begin
                                 // read the current entry first
                                 job_in   = JOB_ARROW;
                                 dir_in   = dir_type'(2'(req.key_byte - KEY_A));
                                 state_in = SEQ_CUR;
                              end else begin
                                 finish = 1'b1;
                              end
                           end
                           default: begin
                              if (req.key_byte inside {KEY_CR, KEY_LF}) begin
                                 job_in   = JOB_CONFIRM;
                                 state_in = SEQ_CUR;
                              end else if (req.key_byte == KEY_ESC) begin
                                 esc_in = ESC_OPEN;
                                 finish = 1'b1;
                              end else begin
                                 // hotkey search starts at entry 0
                                 job_in          = JOB_HOTKEY;
                                 key_in          = fold_case(req.key_byte);
                                 found_in        = 1'b0;
                                 mem_req.rd_addr = '0;
                                 cnt_in          = CW'(1);
                                 chk_vld_in      = (n != '0);
                                 chk_idx_in      = '0;
                                 state_in        = SEQ_SCAN;
                              end
                           end
                        endcase
                     end
                  end
               endcase
            end
         end
         SEQ_CUR: begin
            if (job_ff == JOB_CONFIRM) begin
               active_in  = 1'b0;
               finish     = 1'b1;
               fin_status = ST_CHOSEN;
               fin_key    = rd_data.hotkey;
            end else begin
               cur_row_in      = rd_data.row;
               cur_col_in      = rd_data.col;
               found_in        = 1'b0;
               mem_req.rd_addr = '0;
               cnt_in          = CW'(1);
               chk_vld_in      = (n != '0);
               chk_idx_in      = '0;
               state_in        = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            // issue the next read while the previous entry is compared
            issue      = (cnt_ff < n);
            chk_vld_in = issue;
            chk_idx_in = cnt_ff[AW-1:0];
            if (issue) begin
               mem_req.rd_addr = IDX_W'(cnt_ff[AW-1:0]);
               cnt_in          = cnt_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               if (job_ff == JOB_HOTKEY) begin
                  if (!found_ff && fold_case(rd_data.hotkey) == key_ff) begin
                     found_in    = 1'b1;
                     best_idx_in = chk_idx_ff;
                     best_key_in = rd_data.hotkey;
                  end
               end else begin
                  case (dir_ff)
                     DIR_UP:    ok = (r < cur_row_ff);
                     DIR_DOWN:  ok = (r > cur_row_ff);
                     DIR_RIGHT: ok = (c > cur_col_ff);
                     default:   ok = (c < cur_col_ff);
                  endcase
                  if (dir_ff == DIR_UP || dir_ff == DIR_DOWN) begin
                     p = abs_diff(r, cur_row_ff);
                     s = abs_diff(c, cur_col_ff);
                  end else begin
                     p = abs_diff(c, cur_col_ff);
                     s = abs_diff(r, cur_row_ff);
                  end
                  if (ok && chk_idx_ff != sel_ff &&
                      (!found_ff || p < best_p_ff || (p == best_p_ff && s < best_s_ff))) begin
                     found_in    = 1'b1;
                     best_idx_in = chk_idx_ff;
                     best_p_in   = p;
                     best_s_in   = s;
                  end
               end
            end
            if (!issue && !chk_vld_ff) begin
               finish = 1'b1;
               if (found_ff) begin
                  sel_in = best_idx_ff;
                  if (job_ff == JOB_HOTKEY) begin
                     active_in  = 1'b0;
                     fin_status = ST_CHOSEN;
                     fin_key    = best_key_ff;
                  end else begin
                     fin_status = ST_MOVED;
                  end
               end
            end
         end
         default: begin
            if (res_ready) begin
               state_in = SEQ_IDLE;
            end
         end
      endcase

      if (finish) begin
         state_in = SEQ_DONE;
         res_in   = '{status: fin_status, old_index: 3'(sel_ff), new_index: 3'(sel_in),
                      chosen_key: fin_key, menu_active: active_in};
      end
   end

   assign res = res_ff;

`include "lightbar_menu_navigator_unit_defines.svh"

   `LMN_ASSERT_NOW(a_esc_idle_when_inactive, !active_ff, esc_ff == ESC_NONE, "escape phase left open while menu inactive")
   `LMN_ASSERT_NOW(a_chosen_closes_menu, res_valid && res_ff.status == ST_CHOSEN, !res_ff.menu_active && !active_ff, "menu still active after a choice")
   `LMN_ASSERT_NOW(a_moved_changes_index, res_valid && res_ff.status == ST_MOVED, res_ff.new_index != res_ff.old_index, "move result kept the old index")
   `LMN_ASSERT_NOW(a_scan_within_count, state_ff == SEQ_SCAN && chk_vld_ff, CW'(chk_idx_ff) < n, "scan compared an entry beyond the option count")
   `LMN_ASSERT_NEXT(a_idle_after_take, res_valid && res_ready, state_ff == SEQ_IDLE, "sequencer did not return to idle after a result was taken")

endmodule

// ===== rtl/core/lightbar_menu_navigator_unit.sv =====
// writes, begin, input lost and escape bytes need no table read; a confirm key reads the current entry
// a hotkey scans the table, an arrow reads the current entry and then scans the table; n is option_count
// limited to the table depth, and all n entries are read, one entry per cycle
// one request transaction at a time; the next one is taken only after the previous result has
// left the sequencer for the output stage; a stalled response holds the sequencer
// reset: sync, active high; clears state, control and csr registers; option table undefined until written
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lightbar_menu_navigator_unit
// lightbar menu selection engine with an option table, csr port and output stage
// ----------------------------------------------------------------------------
module lightbar_menu_navigator_unit #(
   parameter int MAX_OPTIONS = 8
) (
   input  logic      clock,
   input  logic      reset,
   lmn_req_if.sink   req_bus,
   lmn_rsp_if.source rsp_bus,
   lmn_csr_if.sink   csr_bus
);
   import lmn_pkg::*;

   // table depth: the index fields reach eight entries at most
   localparam int DEPTH = (MAX_OPTIONS < TABLE_LIMIT) ? MAX_OPTIONS : TABLE_LIMIT;

   logic [3:0]  option_count_ff;
   logic [2:0]  start_index_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   req_type     req;
   mem_req_type mem_req;
   entry_type   rd_data;
   logic        res_valid;
   logic        res_ready;
   rsp_type     res;

   // configuration registers, written by the user only while the block is idle; not enforced
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         option_count_ff <= '0;
         start_index_ff  <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_OPTION_COUNT: option_count_ff <= csr_bus.data;
            default:          start_index_ff  <= csr_bus.data[2:0];
         endcase
      end
   end

   // request payload bundle
   assign req = '{operation: req_bus.operation, entry_index: req_bus.entry_index,
                  entry_row: req_bus.entry_row, entry_col: req_bus.entry_col,
                  entry_hotkey: req_bus.entry_hotkey, key_byte: req_bus.key_byte};

   lmn_option_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // sequencer handles one transaction at a time, so a table read never
   // overlaps a write to the same entry
   lmn_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req          (req),
      .option_count (option_count_ff),
      .start_index  (start_index_ff),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // output stage: frees the sequencer while a result waits to be taken
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_data_ff.status;
   assign rsp_bus.old_index   = rsp_data_ff.old_index;
   assign rsp_bus.new_index   = rsp_data_ff.new_index;
   assign rsp_bus.chosen_key  = rsp_data_ff.chosen_key;
   assign rsp_bus.menu_active = rsp_data_ff.menu_active;

endmodule
